### rtl/jrtqs_pkg.sv
`default_nettype none

package jrtqs_pkg;

  localparam int unsigned TickW = 32;

  localparam logic [2:0] OP_RUNNABLE = 3'd0;
  localparam logic [2:0] OP_TIMED    = 3'd1;
  localparam logic [2:0] OP_CLEAR    = 3'd2;
  localparam logic [2:0] OP_RUN      = 3'd3;
  localparam logic [2:0] OP_ALLOW    = 3'd4;
  localparam logic [2:0] OP_FORBID   = 3'd5;

  typedef struct packed {
    logic ld_item;
    logic drop;
    logic add;
    logic run;
    logic wait_calc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       job_ok;
    logic       out_busy;
  } stat_t;

  // True when a is strictly later than b on the wrapping tick line.
  function automatic logic is_later(input logic [TickW-1:0] a, input logic [TickW-1:0] b);
    logic [TickW-1:0] d;
    d = a - b;
    return (d != '0) && !d[TickW-1];
  endfunction

endpackage

`default_nettype wire

### rtl/jrtqs_req_if.sv
`default_nettype none

interface jrtqs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  job_id;
  logic [31:0] deadline_ticks;
  logic [31:0] now_ticks;

  modport source (output valid, opcode, job_id, deadline_ticks, now_ticks, input ready);
  modport sink (input valid, opcode, job_id, deadline_ticks, now_ticks, output ready);
endinterface

`default_nettype wire

### rtl/jrtqs_res_if.sv
`default_nettype none

interface jrtqs_res_if;
  logic               valid;
  logic               ready;
  logic               dispatched;
  logic [3:0]         run_job;
  logic               from_timer;
  logic signed [31:0] wait_ticks;

  modport source (output valid, dispatched, run_job, from_timer, wait_ticks, input ready);
  modport sink (input valid, dispatched, run_job, from_timer, wait_ticks, output ready);
endinterface

`default_nettype wire

### rtl/job_run_and_timer_queue_scheduler_top.sv
// Channel  Dir  Modport  Payload
// req_i    in   sink     opcode, job_id, deadline_ticks, now_ticks
// res_o    out  source   dispatched, run_job, from_timer, wait_ticks
//
// Every request yields one result. Controller steps over the shifting queue cells:
// decode, push for sleep operations; decode, drop, push for clear; decode, drop,
// add, push for make runnable and set timed; decode, run, wait, push for run once.
// Reset is asynchronous and active low; it empties both queues and forbids sleep.
// A stalled result is held in the output register; the next request is taken
// only when the previous one has moved into that register.
`default_nettype none

module job_run_and_timer_queue_scheduler_top #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  jrtqs_req_if.sink    req_i,
  jrtqs_res_if.source  res_o
);

  jrtqs_pkg::cmd_t  cmd;
  jrtqs_pkg::stat_t stat;
  logic             ready;

  jrtqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  jrtqs_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .res_o  (res_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  a_ready_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready == (ready && req_i.valid))
    else $error("request ready out of step with controller");

endmodule

`default_nettype wire

### rtl/jrtqs_ctrl.sv
`default_nettype none

module jrtqs_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  jrtqs_pkg::stat_t     stat_i,
  output jrtqs_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_DROP = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  logic [2:0] state_q, state_d;
  logic       touches;

  assign touches = stat_i.job_ok &&
                   (stat_i.op == jrtqs_pkg::OP_RUNNABLE || stat_i.op == jrtqs_pkg::OP_TIMED ||
                    stat_i.op == jrtqs_pkg::OP_CLEAR);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.ld_item = in_valid_i;
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        priority if (touches) state_d = S_DROP;
        else if (stat_i.op == jrtqs_pkg::OP_RUN) state_d = S_RUN;
        else state_d = S_PUSH;
      end
      S_DROP: begin
        cmd_o.drop = 1'b1;
        state_d = (stat_i.op == jrtqs_pkg::OP_CLEAR) ? S_PUSH : S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d = S_PUSH;
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        cmd_o.wait_calc = 1'b1;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(cmd_o))
    else $error("controller issued two commands at once");
  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> in_ready_o)
    else $error("controller did not return to idle after a result");
  a_ld_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_item |=> !in_ready_o)
    else $error("controller took a request while busy");

endmodule

`default_nettype wire

### rtl/jrtqs_dp.sv
`default_nettype none

module jrtqs_dp #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  jrtqs_req_if.sink            req_i,
  jrtqs_res_if.source          res_o,
  input  jrtqs_pkg::cmd_t      cmd_i,
  output jrtqs_pkg::stat_t     stat_o
);

  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_JOBS);

  logic [3:0]   run_id_q [MAX_JOBS];
  logic [CW-1:0] run_cnt_q;
  logic [3:0]   tim_id_q [MAX_JOBS];
  logic [31:0]  tim_dl_q [MAX_JOBS];
  logic [CW-1:0] tim_cnt_q;
  logic         sleep_q;

  logic [2:0]   op_q;
  logic [3:0]   job_q;
  logic [31:0]  dl_q;
  logic [31:0]  now_q;

  logic         res_disp_q, res_tmr_q;
  logic [3:0]   res_job_q;
  logic [31:0]  res_wait_q;
  logic         out_vld_q;

  logic [MAX_JOBS-1:0] run_hit, run_after, tim_hit, tim_after, tim_later, tim_ge;
  logic         tim_any, run_pop, tim_pop;
  logic [31:0]  head_diff;

  always_comb begin
    logic ra, ta, ga;
    ra = 1'b0;
    ta = 1'b0;
    ga = 1'b0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      run_hit[i]   = (CW'(i) < run_cnt_q) && (run_id_q[i] == job_q);
      tim_hit[i]   = (CW'(i) < tim_cnt_q) && (tim_id_q[i] == job_q);
      tim_later[i] = (CW'(i) < tim_cnt_q) && jrtqs_pkg::is_later(tim_dl_q[i], dl_q);
      ra = ra | run_hit[i];
      ta = ta | tim_hit[i];
      ga = ga | tim_later[i];
      run_after[i] = ra;
      tim_after[i] = ta;
      tim_ge[i]    = ga;
    end
    tim_any = ga;
  end

  assign head_diff = tim_dl_q[0] - now_q;
  assign run_pop   = cmd_i.run && (run_cnt_q != '0);
  assign tim_pop   = cmd_i.run && (run_cnt_q == '0) && (tim_cnt_q != '0) &&
                     ((head_diff == '0) || head_diff[31]);

  assign stat_o.op       = op_q;
  assign stat_o.job_ok   = 32'(job_q) < 32'(MAX_JOBS);
  assign stat_o.out_busy = out_vld_q && !res_o.ready;
  assign req_i.ready     = cmd_i.ld_item;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      if (cmd_i.drop && run_after[i]) begin
        if (i < MAX_JOBS - 1) run_id_q[i] <= run_id_q[i + 1];
      end else if (run_pop) begin
        if (i < MAX_JOBS - 1) run_id_q[i] <= run_id_q[i + 1];
      end else if (cmd_i.add && op_q == jrtqs_pkg::OP_RUNNABLE &&
                   CW'(i) == run_cnt_q) begin
        run_id_q[i] <= job_q;
      end

      if ((cmd_i.drop && tim_after[i]) || tim_pop) begin
        if (i < MAX_JOBS - 1) begin
          tim_id_q[i] <= tim_id_q[i + 1];
          tim_dl_q[i] <= tim_dl_q[i + 1];
        end
      end else if (cmd_i.add && op_q == jrtqs_pkg::OP_TIMED && tim_cnt_q != FULL) begin
        if (i > 0 && tim_ge[(i > 0) ? i - 1 : 0]) begin
          tim_id_q[i] <= tim_id_q[(i > 0) ? i - 1 : 0];
          tim_dl_q[i] <= tim_dl_q[(i > 0) ? i - 1 : 0];
        end else if (tim_later[i] || (!tim_any && CW'(i) == tim_cnt_q)) begin
          tim_id_q[i] <= job_q;
          tim_dl_q[i] <= dl_q;
        end
      end
    end

    if (cmd_i.ld_item) begin
      op_q  <= req_i.opcode;
      job_q <= req_i.job_id;
      dl_q  <= req_i.deadline_ticks;
      now_q <= req_i.now_ticks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q  <= '0;
      tim_cnt_q  <= '0;
      sleep_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      res_disp_q <= 1'b0;
      res_tmr_q  <= 1'b0;
      res_job_q  <= '0;
      res_wait_q <= '0;
    end else begin
      if (cmd_i.ld_item) begin
        res_disp_q <= 1'b0;
        res_tmr_q  <= 1'b0;
        res_job_q  <= '0;
        res_wait_q <= '0;
        if (req_i.opcode == jrtqs_pkg::OP_CLEAR || req_i.opcode == jrtqs_pkg::OP_ALLOW) begin
          sleep_q <= 1'b1;
        end else if (req_i.opcode == jrtqs_pkg::OP_FORBID) begin
          sleep_q <= 1'b0;
        end
      end
      if (cmd_i.drop) begin
        if (|run_hit) run_cnt_q <= run_cnt_q - 1'b1;
        if (|tim_hit) tim_cnt_q <= tim_cnt_q - 1'b1;
      end
      if (cmd_i.add) begin
        if (op_q == jrtqs_pkg::OP_RUNNABLE && run_cnt_q != FULL) begin
          run_cnt_q <= run_cnt_q + 1'b1;
        end
        if (op_q == jrtqs_pkg::OP_TIMED && tim_cnt_q != FULL) begin
          tim_cnt_q <= tim_cnt_q + 1'b1;
        end
      end
      if (run_pop) begin
        run_cnt_q  <= run_cnt_q - 1'b1;
        res_disp_q <= 1'b1;
        res_job_q  <= run_id_q[0];
      end else if (tim_pop) begin
        tim_cnt_q  <= tim_cnt_q - 1'b1;
        res_disp_q <= 1'b1;
        res_tmr_q  <= 1'b1;
        res_job_q  <= tim_id_q[0];
      end
      if (cmd_i.wait_calc && run_cnt_q == '0 && tim_cnt_q != '0 && sleep_q) begin
        res_wait_q <= head_diff;
      end
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_o.dispatched <= res_disp_q;
      res_o.run_job    <= res_job_q;
      res_o.from_timer <= res_tmr_q;
      res_o.wait_ticks <= $signed(res_wait_q);
    end
  end

  assign res_o.valid = out_vld_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_cnt_q <= FULL) && (tim_cnt_q <= FULL))
    else $error("queue count beyond capacity");
  a_run_once: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(run_hit))
    else $error("job queued twice in the run FIFO");
  a_tim_once: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tim_hit))
    else $error("job queued twice in the timed queue");
  a_drop_gone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop |=> (run_hit == '0) && (tim_hit == '0))
    else $error("job still queued after removal");

endmodule

`default_nettype wire
